// ===== design/tournament_branch_predictor_unit_assert.svh =====
// assertion macros used by the predictor top level
`ifndef TOURNAMENT_BRANCH_PREDICTOR_UNIT_ASSERT_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== design/tbp_pkg.sv =====
package tbp_pkg;

   // default table sizes
   localparam int GHIST_BITS_DEF = 9;
   localparam int LHIST_BITS_DEF = 10;
   localparam int PC_BITS_DEF    = 10;

   // stream layout
   localparam int ADDR_BITS      = 32;
   localparam int TAKEN_BIT      = ADDR_BITS;
   localparam int REQ_TDATA_BITS = 40;
   localparam int RSP_TDATA_BITS = 8;

   // 2-bit saturating counter limits
   localparam logic [1:0] CTR_MAX       = 2'd3;
   localparam logic [1:0] CTR_MIN       = 2'd0;
   localparam logic [1:0] CTR_TAKEN_MIN = 2'd2;

   // result word, prediction in bit 0
   typedef struct packed {
      logic local_guess;
      logic global_guess;
      logic prediction;
   } result_type;

   localparam int RESULT_BITS = $bits(result_type);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_LOOKUP = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

   // saturating step of a 2-bit counter
   function automatic logic [1:0] sat_update(input logic [1:0] ctr, input logic up);
      logic [1:0] res;
      if (up) begin
         res = (ctr == CTR_MAX) ? CTR_MAX : ctr + 2'd1;
      end else begin
         res = (ctr == CTR_MIN) ? CTR_MIN : ctr - 2'd1;
      end
      return res;
   endfunction

endpackage

// ===== design/tbp_ram.sv =====
module tbp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/tbp_train.sv =====
module tbp_train (
   input  logic                 taken,
   input  logic [1:0]           global_ctr,
   input  logic [1:0]           local_ctr,
   input  logic [1:0]           choice_ctr,
   output tbp_pkg::result_type  result,
   output logic [1:0]           global_ctr_next,
   output logic [1:0]           local_ctr_next,
   output logic [1:0]           choice_ctr_next
);
   import tbp_pkg::*;

   logic gg;
   logic lg;

   // component guesses and chooser pick
   assign gg = (global_ctr >= CTR_TAKEN_MIN);
   assign lg = (local_ctr >= CTR_TAKEN_MIN);

   always_comb begin
      result.global_guess = gg;
      result.local_guess  = lg;
      result.prediction   = (choice_ctr < CTR_TAKEN_MIN) ? gg : lg;
   end

   // counter training
   assign global_ctr_next = sat_update(global_ctr, taken);
   assign local_ctr_next  = sat_update(local_ctr, taken);

   // chooser moves only on disagreement, up when local was right
   assign choice_ctr_next = (gg != lg) ? sat_update(choice_ctr, lg == taken) : choice_ctr;

endmodule

// ===== design/tournament_branch_predictor_unit.sv =====
// Tournament branch predictor: each input word is one resolved branch
// (address in tdata[31:0], taken in tdata[32]); each output word gives the
// prediction the tables held before this branch, plus the global and local
// component guesses, after which the tables train on the outcome. An item
// passes through a read of the global/chooser table and of the per-pc
// local history, a dependent read of the local counter table indexed by that
// history, and a write-back of all three memories. The next item is taken
// while a result still waits on the output; the write-back of that next item
// holds until the waiting word is taken. After reset the block clears its
// memories, one entry a cycle, over 2^max(GHIST_BITS, LHIST_BITS, PC_BITS)
// entries (1024 at the defaults) before it accepts the first branch.
module tournament_branch_predictor_unit #(
   parameter int GHIST_BITS = tbp_pkg::GHIST_BITS_DEF,
   parameter int LHIST_BITS = tbp_pkg::LHIST_BITS_DEF,
   parameter int PC_BITS    = tbp_pkg::PC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] branch_address, [32] taken, [39:33] zero
   input  logic [tbp_pkg::REQ_TDATA_BITS-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] prediction, [1] global_guess, [2] local_guess, [7:3] zero
   output logic [tbp_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata
);
   import tbp_pkg::*;

`include "tournament_branch_predictor_unit_assert.svh"

   localparam int MAX_GL   = (GHIST_BITS > LHIST_BITS) ? GHIST_BITS : LHIST_BITS;
   localparam int CLR_BITS = (MAX_GL > PC_BITS) ? MAX_GL : PC_BITS;
   localparam int GC_WIDTH = 4;

   state_type             state_ff, state_in;
   logic [CLR_BITS-1:0]   clr_ff, clr_in;
   logic [GHIST_BITS-1:0] ghist_ff, ghist_in;
   logic [PC_BITS-1:0]    pc_ff;
   logic                  taken_ff;
   logic [LHIST_BITS-1:0] lhist_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_data_ff;

   logic req_fire;
   logic out_free;
   logic do_update;
   logic clearing;

   logic [GC_WIDTH-1:0]   gc_rd;
   logic [LHIST_BITS-1:0] lhist_rd;
   logic [1:0]            lc_rd;

   result_type            result;
   logic [1:0]            global_next;
   logic [1:0]            local_next;
   logic [1:0]            choice_next;

   logic [GHIST_BITS:0]   ghist_shift;
   logic [LHIST_BITS:0]   lhist_shift;

   logic                  gc_we, lh_we, lc_we;
   logic [GHIST_BITS-1:0] gc_waddr;
   logic [GC_WIDTH-1:0]   gc_wdata;
   logic [PC_BITS-1:0]    lh_waddr;
   logic [LHIST_BITS-1:0] lh_wdata;
   logic [LHIST_BITS-1:0] lc_waddr;
   logic [1:0]            lc_wdata;

   // handshake
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign do_update  = (state_ff == ST_UPDATE) && out_free;
   assign clearing   = (state_ff == ST_CLEAR);

   // history shifts
   assign ghist_shift = {ghist_ff, taken_ff};
   assign lhist_shift = {lhist_ff, taken_ff};

   // sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + CLR_BITS'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // global history
   assign ghist_in = do_update ? ghist_shift[GHIST_BITS-1:0] : ghist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ghist_ff <= '0;
      end else begin
         ghist_ff <= ghist_in;
      end
   end

   // branch capture and local history hold
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pc_ff    <= req_tdata[PC_BITS-1:0];
         taken_ff <= req_tdata[TAKEN_BIT];
      end
      if (state_ff == ST_LOOKUP) begin
         lhist_ff <= lhist_rd;
      end
   end

   // write ports: zero sweep or training write-back
   assign gc_we    = clearing || do_update;
   assign lh_we    = clearing || do_update;
   assign lc_we    = clearing || do_update;
   assign gc_waddr = clearing ? clr_ff[GHIST_BITS-1:0] : ghist_ff;
   assign gc_wdata = clearing ? '0 : {choice_next, global_next};
   assign lh_waddr = clearing ? clr_ff[PC_BITS-1:0] : pc_ff;
   assign lh_wdata = clearing ? '0 : lhist_shift[LHIST_BITS-1:0];
   assign lc_waddr = clearing ? clr_ff[LHIST_BITS-1:0] : lhist_ff;
   assign lc_wdata = clearing ? '0 : local_next;

   // chooser and global counters share the global-history index
   tbp_ram #(
      .WIDTH (GC_WIDTH),
      .DEPTH (2 ** GHIST_BITS)
   ) u_gc_ram (
      .clock   (clock),
      .wr_en   (gc_we),
      .wr_addr (gc_waddr),
      .wr_data (gc_wdata),
      .rd_en   (req_fire),
      .rd_addr (ghist_ff),
      .rd_data (gc_rd)
   );

   // per-pc local histories
   tbp_ram #(
      .WIDTH (LHIST_BITS),
      .DEPTH (2 ** PC_BITS)
   ) u_lh_ram (
      .clock   (clock),
      .wr_en   (lh_we),
      .wr_addr (lh_waddr),
      .wr_data (lh_wdata),
      .rd_en   (req_fire),
      .rd_addr (req_tdata[PC_BITS-1:0]),
      .rd_data (lhist_rd)
   );

   // local counters, read once the history is known
   tbp_ram #(
      .WIDTH (2),
      .DEPTH (2 ** LHIST_BITS)
   ) u_lc_ram (
      .clock   (clock),
      .wr_en   (lc_we),
      .wr_addr (lc_waddr),
      .wr_data (lc_wdata),
      .rd_en   (state_ff == ST_LOOKUP),
      .rd_addr (lhist_rd),
      .rd_data (lc_rd)
   );

   // prediction and training
   tbp_train u_train (
      .taken           (taken_ff),
      .global_ctr      (gc_rd[1:0]),
      .local_ctr       (lc_rd),
      .choice_ctr      (gc_rd[3:2]),
      .result          (result),
      .global_ctr_next (global_next),
      .local_ctr_next  (local_next),
      .choice_ctr_next (choice_next)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (do_update) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_update) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_BITS - RESULT_BITS){1'b0}}, rsp_data_ff};

   // checks
   `ASSERT_NEXT(a_fire_to_lookup, clock, reset, req_fire, state_ff == ST_LOOKUP, "accepted word did not start a lookup")
   `ASSERT_NEXT(a_update_gives_word, clock, reset, do_update, rsp_tvalid, "finished update produced no word")
   `ASSERT_IMPLIES(a_no_word_while_clearing, clock, reset, clearing, !rsp_valid_ff, "word offered during clearing pass")
   `ASSERT_NEXT(a_ghist_only_on_update, clock, reset, !do_update, $stable(ghist_ff), "global history moved outside write-back")

endmodule

// ===== sim/tournament_branch_predictor_unit_test.sv =====
module tournament_branch_predictor_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tbp_pkg::*;

   localparam int GH_ENTRIES = 1 << GHIST_BITS_DEF;
   localparam int LH_ENTRIES = 1 << LHIST_BITS_DEF;
   localparam int PC_ENTRIES = 1 << PC_BITS_DEF;
   // chooser entries at or above this pick the local guess
   localparam logic [1:0] CHOOSE_LOCAL_MIN = 2'd2;
   localparam int RANDOM_BRANCHES = 800;
   localparam int QUIET_FROM      = 700;
   localparam int DRAIN_CYCLES    = 20;
   localparam int POOL_SIZE       = 8;

   // one row of the directed table
   typedef struct {
      logic [ADDR_BITS-1:0] addr;
      logic                 taken;
      bit                   known;
      result_type           guess;
   } branch_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   // [31:0] branch_address, [32] taken, [39:33] zero
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // [0] prediction, [1] global_guess, [2] local_guess, [7:3] zero
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;

   // shadow copy of the predictor tables
   logic [GHIST_BITS_DEF-1:0] glob_history;
   logic [1:0]                glob_ctr   [GH_ENTRIES];
   logic [1:0]                choice_ctr [GH_ENTRIES];
   logic [LHIST_BITS_DEF-1:0] loc_history[PC_ENTRIES];
   logic [1:0]                loc_ctr    [LH_ENTRIES];

   result_type pending_guesses[$];
   int         mismatches = 0;
   bit         quiet = 1'b0;

   branch_row_type directed_rows[] = '{
      '{32'h0000_0000, 1'b0, 1'b1, 3'b000},
      '{32'hFFFF_FFFF, 1'b1, 1'b1, 3'b000},
      '{32'hFFFF_FC00, 1'b1, 1'b0, 3'b000},
      '{32'h0000_0400, 1'b1, 1'b0, 3'b000},
      '{32'h8000_0000, 1'b1, 1'b0, 3'b000},
      '{32'h0000_03FF, 1'b1, 1'b0, 3'b000},
      '{32'h0000_03FF, 1'b1, 1'b0, 3'b000},
      '{32'h0000_03FF, 1'b1, 1'b0, 3'b000},
      '{32'h0000_03FF, 1'b1, 1'b0, 3'b000},
      '{32'h0000_03FF, 1'b0, 1'b0, 3'b000},
      '{32'h0000_03FF, 1'b1, 1'b0, 3'b000},
      '{32'h1234_5678, 1'b1, 1'b0, 3'b000},
      '{32'hEDCB_A987, 1'b0, 1'b0, 3'b000},
      '{32'h1234_5678, 1'b1, 1'b0, 3'b000},
      '{32'hEDCB_A987, 1'b0, 1'b0, 3'b000},
      '{32'h0000_0155, 1'b1, 1'b0, 3'b000},
      '{32'h0000_0155, 1'b1, 1'b0, 3'b000},
      '{32'h0000_0155, 1'b1, 1'b0, 3'b000},
      '{32'h0000_02AA, 1'b0, 1'b0, 3'b000},
      '{32'h0000_02AA, 1'b0, 1'b0, 3'b000},
      '{32'h0000_02AA, 1'b1, 1'b0, 3'b000},
      '{32'hAAAA_A955, 1'b1, 1'b0, 3'b000},
      '{32'h5555_56AA, 1'b0, 1'b0, 3'b000}
   };

   tournament_branch_predictor_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // saturating 2-bit counter step
   function automatic logic [1:0] bump_counter(input logic [1:0] ctr, input logic up);
      if (up) begin
         return (ctr == CTR_MAX) ? ctr : ctr + 2'd1;
      end
      return (ctr == CTR_MIN) ? ctr : ctr - 2'd1;
   endfunction

   // guesses from the tables as they stand, then train on the outcome
   function automatic result_type resolve_branch(input logic [ADDR_BITS-1:0] addr,
                                                 input logic taken);
      logic [PC_BITS_DEF-1:0]    pc;
      logic [GHIST_BITS_DEF-1:0] gh;
      logic [LHIST_BITS_DEF-1:0] lh;
      result_type                r;
      pc = addr[PC_BITS_DEF-1:0];
      gh = glob_history;
      lh = loc_history[pc];
      r.global_guess = (glob_ctr[gh] >= CTR_TAKEN_MIN);
      r.local_guess  = (loc_ctr[lh] >= CTR_TAKEN_MIN);
      r.prediction   = (choice_ctr[gh] >= CHOOSE_LOCAL_MIN) ? r.local_guess
                                                              : r.global_guess;
      glob_ctr[gh] = bump_counter(glob_ctr[gh], taken);
      loc_ctr[lh]  = bump_counter(loc_ctr[lh], taken);
      // chooser leans toward whichever side was right, only on disagreement
      if (r.global_guess != r.local_guess) begin
         choice_ctr[gh] = bump_counter(choice_ctr[gh], r.local_guess == taken);
      end
      glob_history    = {gh[GHIST_BITS_DEF-2:0], taken};
      loc_history[pc] = {lh[LHIST_BITS_DEF-2:0], taken};
      return r;
   endfunction

   // present one branch word and wait for it to be taken
   task automatic send_branch(input logic [ADDR_BITS-1:0] addr, input logic taken,
                              input bit known, input result_type typed);
      result_type guess;
      req_tdata  <= {{(REQ_TDATA_BITS-ADDR_BITS-1){1'b0}}, taken, addr};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      guess = resolve_branch(addr, taken);
      pending_guesses.push_back(known ? typed : guess);
   endtask

   // occasional sender gap
   task automatic maybe_idle(input int rate);
      if (!quiet && rate != 0 && $urandom_range(0, 9) < rate) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic flag_mismatch(input string what, input logic want, input logic got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch on %s: expected %0b, got %0b", what, want, got);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[RESULT_BITS-1:0]);
         if (pending_guesses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result word %b", rsp_tdata);
            end
         end else begin
            want = pending_guesses.pop_front();
            if (got.prediction !== want.prediction) begin
               flag_mismatch("prediction", want.prediction, got.prediction);
            end
            if (got.global_guess !== want.global_guess) begin
               flag_mismatch("global_guess", want.global_guess, got.global_guess);
            end
            if (got.local_guess !== want.local_guess) begin
               flag_mismatch("local_guess", want.local_guess, got.local_guess);
            end
         end
      end
   end

   // receiver stalls, in phases of varying density
   initial begin : rsp_side
      int rate;
      int span;
      rate = 0;
      span = 0;
      forever begin
         @(posedge clock);
         if (span == 0) begin
            rate = $urandom_range(0, 3);
            span = $urandom_range(20, 60);
         end
         span--;
         if (!reset && !quiet && rate != 0 && $urandom_range(0, 9) < rate) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // run limit: clearing pass plus every branch at its slowest, many times over
   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // stimulus
   initial begin : stimulus
      logic [PC_BITS_DEF-1:0] pool_pc    [POOL_SIZE];
      int                     pool_period[POOL_SIZE];
      int                     pool_count [POOL_SIZE];
      logic [ADDR_BITS-1:0]   addr;
      logic                   taken;
      int                     rate;
      int                     span;
      int                     pick;
      int                     pause_at;
      result_type             none;

      none = '0;
      glob_history = '0;
      foreach (glob_ctr[i]) begin
         glob_ctr[i]   = CTR_MIN;
         choice_ctr[i] = CTR_MIN;
      end
      foreach (loc_history[i]) loc_history[i] = '0;
      foreach (loc_ctr[i]) loc_ctr[i] = CTR_MIN;

      // loop-like branches: taken except once per period
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_pc[i]     = PC_BITS_DEF'($urandom);
         pool_period[i] = $urandom_range(1, 9);
         pool_count[i]  = 0;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table, back to back
      foreach (directed_rows[i]) begin
         send_branch(directed_rows[i].addr, directed_rows[i].taken,
                     directed_rows[i].known, directed_rows[i].guess);
      end

      rate     = 0;
      span     = 0;
      pause_at = $urandom_range(200, 500);
      for (int n = 0; n < RANDOM_BRANCHES; n++) begin
         if (n >= QUIET_FROM) begin
            quiet = 1'b1;
         end
         if (span == 0) begin
            rate = $urandom_range(0, 3);
            span = $urandom_range(20, 60);
         end
         span--;

         // hold off until every outstanding word has come back
         if (n == pause_at) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (pending_guesses.size() != 0);
         end else begin
            maybe_idle(rate);
         end

         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            // known branch with random high address bits
            pick  = $urandom_range(0, POOL_SIZE - 1);
            addr  = $urandom;
            addr[PC_BITS_DEF-1:0] = pool_pc[pick];
            pool_count[pick]++;
            taken = (pool_count[pick] % (pool_period[pick] + 1)) != 0;
            if ($urandom_range(0, 19) == 0) begin
               taken = !taken;
            end
         end else begin
            addr  = $urandom;
            taken = 1'($urandom_range(0, 1));
         end
         send_branch(addr, taken, 1'b0, none);
      end
      req_tvalid <= 1'b0;

      // drain
      while (pending_guesses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_guesses.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
